FILE: hdl/wmsf_pkg.sv
// Shared constants and types for the windowed median speed filter.
package wmsf_pkg;

  localparam int WINDOW      = 5;
  localparam int SPEED_W     = 16;
  localparam int POS_W       = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int RANK_W      = $clog2(WINDOW);
  localparam int MEDIAN_RANK = WINDOW / 2;

  // Reset threshold, about 0.05 in Q8.8.
  localparam logic [SPEED_W-1:0] THRESHOLD_RESET = SPEED_W'(13);

  typedef logic [SPEED_W-1:0] speed_t;
  typedef speed_t window_t [WINDOW];

endpackage

FILE: hdl/wmsf_if.sv
// Stream interfaces for speed samples in and filtered results out.
interface wmsf_sample_if
  import wmsf_pkg::*;
  ();
  logic   valid;
  logic   ready;
  speed_t speed_sample;

  modport source (output valid, output speed_sample, input ready);
  modport sink   (input valid, input speed_sample, output ready);
endinterface

interface wmsf_result_if
  import wmsf_pkg::*;
  ();
  logic   valid;
  logic   ready;
  speed_t filtered_speed;
  logic   from_median;

  modport source (output valid, output filtered_speed, output from_median, input ready);
  modport sink   (input valid, input filtered_speed, input from_median, output ready);
endinterface

FILE: hdl/wmsf_median.sv
// Rank-select compare network: picks the middle element of the window.
module wmsf_median
  import wmsf_pkg::*;
(
  input  window_t win,
  output speed_t  median
);

  logic [RANK_W-1:0] rank [WINDOW];

  // Rank each entry; ties break by position so exactly one entry has each rank
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j < i) begin
          if (win[j] <= win[i]) rank[i] = rank[i] + RANK_W'(1);
        end else if (j > i) begin
          if (win[j] < win[i]) rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // Select the entry whose rank is the middle one
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == RANK_W'(MEDIAN_RANK)) median = median | win[i];
    end
  end

endmodule

FILE: hdl/windowed_median_speed_filter.sv
// Windowed running-median speed filter: top level.
// Takes one Q8.8 speed sample per cycle unless the result side stalls, and
// returns one result per sample via the input register, then the result
// register; the five-entry rank-select compare network and the window update
// sit between those registers. A sample below zero_threshold clears the window
// and yields zero; while the window fills the raw sample is returned; once
// full, the median of the last five samples is returned with from_median set.
// zero_threshold resets to 13 (about 0.05); write it via zero_threshold_we /
// zero_threshold_wdata only while the block is idle; it is not enforced.
module windowed_median_speed_filter
  import wmsf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                zero_threshold_we,
  input  speed_t              zero_threshold_wdata,
  wmsf_sample_if.sink         sample_in,
  wmsf_result_if.source       result_out
);

  speed_t            zero_threshold;
  logic              s1_valid;
  speed_t            s1_sample;
  window_t           window_store;
  window_t           window_next;
  logic [POS_W-1:0]  write_position;
  logic [POS_W-1:0]  write_position_next;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_count_next;
  logic              res_valid;
  speed_t            res_speed;
  logic              res_median;
  speed_t            res_speed_next;
  logic              res_median_next;
  speed_t            median;
  logic              advance;
  logic              stop;
  logic              full;

  // Stage control: result register frees up when empty or taken
  assign advance         = !res_valid || result_out.ready;
  assign sample_in.ready = !s1_valid || advance;

  assign result_out.valid          = res_valid;
  assign result_out.filtered_speed = res_speed;
  assign result_out.from_median    = res_median;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= THRESHOLD_RESET;
    end else if (zero_threshold_we) begin
      zero_threshold <= zero_threshold_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_in.ready) begin
      s1_valid <= sample_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      s1_sample <= sample_in.speed_sample;
    end
  end

  assign stop = s1_sample < zero_threshold;
  assign full = fill_count == CNT_W'(WINDOW);

  // Window update: clear on stop, else write the sample at the write position
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      if (stop) begin
        window_next[i] = '0;
      end else if (write_position == POS_W'(i)) begin
        window_next[i] = s1_sample;
      end else begin
        window_next[i] = window_store[i];
      end
    end
  end

  always_comb begin
    if (stop) begin
      write_position_next = '0;
      fill_count_next     = '0;
    end else begin
      if (write_position == POS_W'(WINDOW - 1)) begin
        write_position_next = '0;
      end else begin
        write_position_next = write_position + POS_W'(1);
      end
      fill_count_next = full ? fill_count : fill_count + CNT_W'(1);
    end
  end

  wmsf_median u_median (
    .win    (window_next),
    .median (median)
  );

  // Choose zero, raw sample or median
  always_comb begin
    if (stop) begin
      res_speed_next  = '0;
      res_median_next = 1'b0;
    end else if (!full) begin
      res_speed_next  = s1_sample;
      res_median_next = 1'b0;
    end else begin
      res_speed_next  = median;
      res_median_next = 1'b1;
    end
  end

  // Window state advances as each beat moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      fill_count     <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        window_store[i] <= '0;
      end
    end else if (s1_valid && advance) begin
      write_position <= write_position_next;
      fill_count     <= fill_count_next;
      window_store   <= window_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      res_speed  <= res_speed_next;
      res_median <= res_median_next;
    end
  end

  // Checks on window bookkeeping
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count beyond window size");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    write_position < POS_W'(WINDOW))
    else $error("write position beyond window");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && stop |=>
      fill_count == '0 && write_position == '0 && res_valid && !res_median
      && res_speed == '0)
    else $error("stop sample did not clear window");

  a_fill_raw: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && !stop && !full |=>
      res_valid && !res_median && res_speed == $past(s1_sample))
    else $error("filling window did not pass raw sample");

  a_median_when_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && !stop && full |=> res_valid && res_median && full)
    else $error("full window did not give median");

endmodule
